// ----- rtl/core/rbst_pkg.sv -----
// Package: shared constants and types for the ray/box slab test.
package rbst_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    // saturated width of a slab distance
    localparam int QBITS          = 48;
    localparam int AXES           = 3;

    // per-axis flags and the zero-direction miss flag, carried alongside the divider pipeline
    typedef struct packed {
        logic [AXES-1:0] dir_neg;
        logic [AXES-1:0] dir_zero;
        logic [AXES-1:0] lo_neg;
        logic [AXES-1:0] hi_neg;
        logic            zero_miss;
    } side_t;

endpackage

// ----- rtl/core/rbst_in_if.sv -----
// Interface: ray/box test input channel.
interface rbst_in_if #(
    parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

// ----- rtl/core/rbst_out_if.sv -----
// Interface: ray/box test result channel.
interface rbst_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

// ----- rtl/core/ray_box_slab_test.sv -----
// Top level: pipelined ray versus axis-aligned box slab test.
//
// Usage:
//   ray_in  carries one ray/box test per transaction (origin, direction, box
//   corners, signed Q(COORD_BITS-FRAC_BITS).FRAC_BITS). hit_out returns one
//   hit bit per test, in order.
//   Stages: an input stage, the six bit-per-stage dividers of
//   COORD_BITS + 1 + FRAC_BITS stages, then the clamp, min/max and output
//   stages.
//   Throughput: one test per cycle while hit_out.ready is high.
//   Stall: the whole pipeline holds while the output register is full and
//   hit_out.ready is low; ray_in.ready drops in the same cycle. Nothing is
//   lost or repeated.
//   Reset: rst_n clears all valid bits; the pipeline comes up empty and ready.
//   A hit needs exit > entry; touching is a miss. A zero direction component
//   misses when the origin lies outside that slab.
module ray_box_slab_test #(
    parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rbst_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rbst_in_if.sink    ray_in,
    rbst_out_if.source hit_out
);
    import rbst_pkg::*;

    localparam int NB = COORD_BITS + 1;
    localparam int NW = NB + FRAC_BITS;
    localparam int QW = ((NW > QBITS) ? NW : QBITS) + 1;
    localparam int TB = QBITS + 1;

    localparam logic [QW-1:0] QMIN_MAG = QW'(1) << (QBITS - 1);
    localparam logic [QW-1:0] QMAX_MAG = QMIN_MAG - QW'(1);
    localparam logic signed [TB-1:0] ENTRY_INIT =
        -$signed({1'b0, QMIN_MAG[TB-2:0]}) - $signed(TB'(1));
    localparam logic signed [TB-1:0] EXIT_INIT  = $signed({1'b0, QMIN_MAG[TB-2:0]});

    logic en;
    logic vo_reg;

    // pipeline advance
    assign en           = !vo_reg || hit_out.ready;
    assign ray_in.ready = en;

    // axis views of the input fields
    logic signed [COORD_BITS-1:0] org [0:AXES-1];
    logic signed [COORD_BITS-1:0] dir [0:AXES-1];
    logic signed [COORD_BITS-1:0] bmn [0:AXES-1];
    logic signed [COORD_BITS-1:0] bmx [0:AXES-1];

    assign org[0] = ray_in.origin_x;
    assign org[1] = ray_in.origin_y;
    assign org[2] = ray_in.origin_z;
    assign dir[0] = ray_in.dir_x;
    assign dir[1] = ray_in.dir_y;
    assign dir[2] = ray_in.dir_z;
    assign bmn[0] = ray_in.box_min_x;
    assign bmn[1] = ray_in.box_min_y;
    assign bmn[2] = ray_in.box_min_z;
    assign bmx[0] = ray_in.box_max_x;
    assign bmx[1] = ray_in.box_max_y;
    assign bmx[2] = ray_in.box_max_z;

    // input stage: slab offsets, magnitudes and flags
    logic [NB-1:0]         nmag_next [0:2*AXES-1];
    logic [COORD_BITS-1:0] dmag_next [0:AXES-1];
    side_t                 side_next;

    always_comb
    begin
        logic signed [NB-1:0] dlo;
        logic signed [NB-1:0] dhi;
        side_next = '0;
        for (int a = 0; a < AXES; a++)
        begin
            dlo = NB'(bmn[a]) - NB'(org[a]);
            dhi = NB'(bmx[a]) - NB'(org[a]);
            nmag_next[2*a]   = dlo[NB-1] ? NB'(-dlo) : NB'(dlo);
            nmag_next[2*a+1] = dhi[NB-1] ? NB'(-dhi) : NB'(dhi);
            dmag_next[a]     = dir[a][COORD_BITS-1] ? COORD_BITS'(-dir[a])
                                                    : COORD_BITS'(dir[a]);
            side_next.lo_neg[a]   = dlo[NB-1];
            side_next.hi_neg[a]   = dhi[NB-1];
            side_next.dir_neg[a]  = dir[a][COORD_BITS-1];
            side_next.dir_zero[a] = (dir[a] == '0);
            if ((dir[a] == '0) && ((org[a] < bmn[a]) || (org[a] > bmx[a])))
                side_next.zero_miss = 1'b1;
        end
    end

    logic [NB-1:0]         nmag_reg [0:2*AXES-1];
    logic [COORD_BITS-1:0] dmag_reg [0:AXES-1];
    logic                  vs_reg   [0:NW];
    side_t                 side_reg [0:NW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg    <= nmag_next;
            dmag_reg    <= dmag_next;
            side_reg[0] <= side_next;
            for (int k = 0; k < NW; k++)
                side_reg[k+1] <= side_reg[k];
        end
    end

    // valid bits alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NW; k++)
                vs_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vs_reg[0] <= ray_in.valid;
            for (int k = 0; k < NW; k++)
                vs_reg[k+1] <= vs_reg[k];
        end
    end

    // six dividers: per axis, low and high bound
    logic [NW-1:0] quo [0:2*AXES-1];

    for (genvar j = 0; j < 2*AXES; j++) begin : g_div
        rbst_div_pipe #(
            .NUM_BITS  (NB),
            .DEN_BITS  (COORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (nmag_reg[j]),
            .den (dmag_reg[j/2]),
            .quo (quo[j])
        );
    end

    // clamp stage: signed saturated distances, swap, zero-direction limits
    logic signed [TB-1:0] te_next [0:AXES-1];
    logic signed [TB-1:0] tx_next [0:AXES-1];
    side_t                sd;

    assign sd = side_reg[NW];

    always_comb
    begin
        logic [QW-1:0]        qs;
        logic                 neg;
        logic signed [TB-1:0] t [0:1];
        for (int a = 0; a < AXES; a++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                qs  = QW'(quo[2*a+b]);
                if (qs > QMIN_MAG)
                    qs = QMIN_MAG;
                neg = ((b == 0) ? sd.lo_neg[a] : sd.hi_neg[a]) ^ sd.dir_neg[a];
                if (neg)
                    t[b] = -$signed({1'b0, qs[TB-2:0]});
                else if (qs > QMAX_MAG)
                    t[b] = $signed({1'b0, QMAX_MAG[TB-2:0]});
                else
                    t[b] = $signed({1'b0, qs[TB-2:0]});
            end
            if (sd.dir_zero[a])
            begin
                te_next[a] = ENTRY_INIT;
                tx_next[a] = EXIT_INIT;
            end
            else if (sd.dir_neg[a])
            begin
                te_next[a] = t[1];
                tx_next[a] = t[0];
            end
            else
            begin
                te_next[a] = t[0];
                tx_next[a] = t[1];
            end
        end
    end

    logic signed [TB-1:0] te_reg [0:AXES-1];
    logic signed [TB-1:0] tx_reg [0:AXES-1];
    logic                 missa_reg;
    logic                 va_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            te_reg    <= te_next;
            tx_reg    <= tx_next;
            missa_reg <= sd.zero_miss;
        end
    end

    // max entry, min exit
    logic signed [TB-1:0] entry_next;
    logic signed [TB-1:0] exit_next;

    always_comb
    begin
        entry_next = te_reg[0];
        exit_next  = tx_reg[0];
        for (int a = 1; a < AXES; a++)
        begin
            if (te_reg[a] > entry_next)
                entry_next = te_reg[a];
            if (tx_reg[a] < exit_next)
                exit_next = tx_reg[a];
        end
    end

    logic signed [TB-1:0] entry_reg;
    logic signed [TB-1:0] exit_reg;
    logic                 missb_reg;
    logic                 vb_reg;
    logic                 hit_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
            missb_reg <= missa_reg;
            hit_reg   <= !(missb_reg || (exit_reg <= entry_reg));
        end
    end

    // valid bits of the tail stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= vs_reg[NW];
            vb_reg <= va_reg;
            vo_reg <= vb_reg;
        end
    end

    assign hit_out.valid = vo_reg;
    assign hit_out.hit   = hit_reg;

endmodule

// ----- rtl/core/rbst_div_pipe.sv -----
// Module: pipelined restoring divider, one quotient bit per stage.
module rbst_div_pipe #(
    parameter int NUM_BITS  = rbst_pkg::COORD_BITS_DEF + 1,
    parameter int DEN_BITS  = rbst_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [NUM_BITS-1:0]           num,
    input  logic [DEN_BITS-1:0]           den,
    output logic [NUM_BITS+FRAC_BITS-1:0] quo
);
    localparam int NW = NUM_BITS + FRAC_BITS;

    logic [DEN_BITS-1:0] rem_in [0:NW-1];
    logic [NW-1:0]       dvd_in [0:NW-1];
    logic [NW-1:0]       quo_in [0:NW-1];
    logic [DEN_BITS-1:0] den_in [0:NW-1];

    logic [DEN_BITS-1:0] rem_reg [0:NW-1];
    logic [NW-1:0]       dvd_reg [0:NW-1];
    logic [NW-1:0]       quo_reg [0:NW-1];
    logic [DEN_BITS-1:0] den_reg [0:NW-1];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DEN_BITS:0]   rem_sh;
        logic [DEN_BITS:0]   rem_sub;
        logic                ge;
        logic [DEN_BITS-1:0] rem_next;

        // stage inputs: dividend is num scaled by the fraction bits
        if (k == 0) begin : g_first
            assign rem_in[k] = '0;
            assign dvd_in[k] = {num, {FRAC_BITS{1'b0}}};
            assign quo_in[k] = '0;
            assign den_in[k] = den;
        end else begin : g_next
            assign rem_in[k] = rem_reg[k-1];
            assign dvd_in[k] = dvd_reg[k-1];
            assign quo_in[k] = quo_reg[k-1];
            assign den_in[k] = den_reg[k-1];
        end

        // shift in next dividend bit, trial subtract
        assign rem_sh   = {rem_in[k], dvd_in[k][NW-1]};
        assign rem_sub  = rem_sh - {1'b0, den_in[k]};
        assign ge       = (rem_sh >= {1'b0, den_in[k]});
        assign rem_next = ge ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                dvd_reg[k] <= {dvd_in[k][NW-2:0], 1'b0};
                quo_reg[k] <= {quo_in[k][NW-2:0], ge};
                den_reg[k] <= den_in[k];
            end
        end
    end

    assign quo = quo_reg[NW-1];

endmodule

// ----- bench/ray_box_slab_test_test.sv -----
// Testbench for the ray/box slab test: random and directed rays against a local slab predictor.
module ray_box_slab_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbst_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int NUM_RANDOM = 700;
    localparam int DRAIN_CYCLES = 80;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [QBITS-1:0] dist_t;

    typedef struct {
        coord_t org [AXES];
        coord_t dir [AXES];
        coord_t bmin [AXES];
        coord_t bmax [AXES];
    } ray_box_t;

    logic clk;
    logic rst_n;

    rbst_in_if  #(.COORD_BITS(CB)) ray_in ();
    rbst_out_if hit_out ();

    ray_box_slab_test #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .ray_in  (ray_in.sink),
        .hit_out (hit_out.source)
    );

    ray_box_t pending_rays [$];
    logic     expected_hits [$];
    int       error_count;
    bit       stimulus_done;
    bit       hold_for_drain;

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Fixed-point slab distance: num * 2^FB / den, truncated, saturated to QBITS
    function automatic longint slab_dist(longint num, longint den);
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] qi;
        logic [63:0] qm;
        logic [63:0] qmax;
        logic [63:0] qmin;
        bit          neg;
        n    = (num < 0) ? -num : num;
        m    = (den < 0) ? -den : den;
        qmax = (64'd1 << (QBITS - 1)) - 1;
        qmin = 64'd1 << (QBITS - 1);
        neg  = (num < 0) != (den < 0);
        qi   = n / m;
        if ((qi >> (QBITS - 1 - FB)) != 0)
            qm = qmin;
        else
            qm = (n << FB) / m;
        if (n == 0)
            return 0;
        if (neg)
        begin
            if (qm > qmin)
                qm = qmin;
            return -longint'(qm);
        end
        if (qm > qmax)
            qm = qmax;
        return longint'(qm);
    endfunction

    // Hit prediction across the three slabs
    function automatic logic predict_hit(ray_box_t r);
        longint entry_d;
        longint exit_d;
        longint t0;
        longint t1;
        longint sw;
        longint o;
        longint d;
        bit     miss;
        entry_d = -(longint'(1) << (QBITS - 1)) - 1;
        exit_d  = longint'(1) << (QBITS - 1);
        miss    = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            o = r.org[a];
            d = r.dir[a];
            if (d == 0)
            begin
                if (o < longint'(r.bmin[a]) || o > longint'(r.bmax[a]))
                    miss = 1'b1;
                continue;
            end
            t0 = slab_dist(longint'(r.bmin[a]) - o, d);
            t1 = slab_dist(longint'(r.bmax[a]) - o, d);
            if (d < 0)
            begin
                sw = t0;
                t0 = t1;
                t1 = sw;
            end
            if (t0 > entry_d)
                entry_d = t0;
            if (t1 < exit_d)
                exit_d = t1;
        end
        if (exit_d <= entry_d)
            miss = 1'b1;
        return !miss;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Append one ray to the pending queue
    task automatic add_ray(ray_box_t r);
        pending_rays = {pending_rays, r};
    endtask

    // Random coordinate: mostly small, sometimes extreme or full range
    function automatic coord_t rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return coord_t'($signed($urandom_range(0, 32'h000A0000)) - 32'sh00050000);
        if (sel == 6)
            return coord_t'($urandom);
        if (sel == 7)
            return {1'b1, {(CB-1){1'b0}}};
        if (sel == 8)
            return {1'b0, {(CB-1){1'b1}}};
        return coord_t'($signed($urandom_range(0, 8)) - 4);
    endfunction

    function automatic ray_box_t rand_ray();
        ray_box_t r;
        coord_t   a;
        coord_t   b;
        for (int i = 0; i < AXES; i++)
        begin
            r.org[i] = rand_coord();
            r.dir[i] = ($urandom_range(0, 7) == 0) ? coord_t'(0) : rand_coord();
            a = rand_coord();
            b = rand_coord();
            // mostly well-formed boxes, some inverted
            if ($urandom_range(0, 7) != 0 && a > b)
            begin
                r.bmin[i] = b;
                r.bmax[i] = a;
            end
            else
            begin
                r.bmin[i] = a;
                r.bmax[i] = b;
            end
        end
        return r;
    endfunction

    function automatic ray_box_t make_ray(coord_t o, coord_t d, coord_t lo, coord_t hi);
        ray_box_t r;
        for (int i = 0; i < AXES; i++)
        begin
            r.org[i]  = o;
            r.dir[i]  = d;
            r.bmin[i] = lo;
            r.bmax[i] = hi;
        end
        return r;
    endfunction

    // Stimulus
    initial
    begin
        ray_box_t r;
        coord_t   one;
        coord_t   cmin;
        coord_t   cmax;
        one  = coord_t'(32'h00010000);
        cmin = {1'b1, {(CB-1){1'b0}}};
        cmax = {1'b0, {(CB-1){1'b1}}};
        stimulus_done  = 1'b0;
        hold_for_drain = 1'b0;
        // Directed: plain hit, negative dir, zero dir inside and outside
        add_ray(make_ray(0, one, -one, one));
        add_ray(make_ray(0, -one, -one, one));
        add_ray(make_ray(0, 0, -one, one));
        add_ray(make_ray(2 * one, 0, -one, one));
        add_ray(make_ray(one, 0, -one, one));
        // Touching box (zero-width slab) and inverted box
        add_ray(make_ray(0, one, one, one));
        add_ray(make_ray(0, one, one, -one));
        // Box behind origin
        add_ray(make_ray(4 * one, one, -one, one));
        // Saturation: tiny direction, huge distances
        add_ray(make_ray(cmin, 1, cmax, cmax));
        add_ray(make_ray(cmax, -1, cmin, cmax));
        add_ray(make_ray(cmax, 1, cmin, cmin));
        add_ray(make_ray(cmin, cmin, cmin, cmax));
        add_ray(make_ray(cmax, cmax, cmin, cmax));
        add_ray(make_ray(cmin, cmax, cmax, cmin));
        add_ray(make_ray(-1, -1, 0, 0));
        // Mixed axes: one zero-direction miss among hitting axes, then one axis whose slab lies behind the ray
        r = make_ray(0, one, -one, one);
        r.dir[1] = 0;
        r.org[1] = 5 * one;
        add_ray(r);
        r = make_ray(0, one, -one, one);
        r.dir[2] = -one;
        r.bmin[2] = 3 * one;
        r.bmax[2] = 4 * one;
        add_ray(r);
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            add_ray(rand_ray());
            // pause until drained, once midway
            if (i == NUM_RANDOM / 2)
            begin
                wait (pending_rays.size() == 0);
                hold_for_drain = 1'b1;
                wait (expected_hits.size() == 0);
                hold_for_drain = 1'b0;
            end
        end
        wait (pending_rays.size() == 0);
        stimulus_done = 1'b1;
    end

    // Reset and end of run
    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (stimulus_done && !ray_in.valid && expected_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_hits.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Timeout
    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Driver: bursts of random length with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_in.valid     <= 1'b0;
            ray_in.origin_x  <= '0;
            ray_in.origin_y  <= '0;
            ray_in.origin_z  <= '0;
            ray_in.dir_x     <= '0;
            ray_in.dir_y     <= '0;
            ray_in.dir_z     <= '0;
            ray_in.box_min_x <= '0;
            ray_in.box_min_y <= '0;
            ray_in.box_min_z <= '0;
            ray_in.box_max_x <= '0;
            ray_in.box_max_y <= '0;
            ray_in.box_max_z <= '0;
            burst_left       <= 0;
            gap_left         <= 0;
        end
        else if (!ray_in.valid || ray_in.ready)
        begin
            // accepted transaction leaves the queue; the next one is at the front
            if (ray_in.valid)
                expected_hits = {expected_hits, predict_hit(pending_rays.pop_front())};
            if (gap_left > 0)
            begin
                gap_left     <= gap_left - 1;
                ray_in.valid <= 1'b0;
            end
            else if (pending_rays.size() > 0 && !hold_for_drain)
            begin
                ray_box_t r;
                r = pending_rays[0];
                ray_in.valid     <= 1'b1;
                ray_in.origin_x  <= r.org[0];
                ray_in.origin_y  <= r.org[1];
                ray_in.origin_z  <= r.org[2];
                ray_in.dir_x     <= r.dir[0];
                ray_in.dir_y     <= r.dir[1];
                ray_in.dir_z     <= r.dir[2];
                ray_in.box_min_x <= r.bmin[0];
                ray_in.box_min_y <= r.bmin[1];
                ray_in.box_min_z <= r.bmin[2];
                ray_in.box_max_x <= r.bmax[0];
                ray_in.box_max_y <= r.bmax[1];
                ray_in.box_max_z <= r.bmax[2];
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                ray_in.valid <= 1'b0;
        end
    end

    // Receiver stall pattern: phases of full speed and of random stalls
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_out.ready <= 1'b0;
            stall_phase   <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 300;
            if (stall_phase < 100)
                hit_out.ready <= 1'b1;
            else if (stall_phase < 200)
                hit_out.ready <= ($urandom_range(0, 3) != 0);
            else
                hit_out.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && hit_out.valid && hit_out.ready)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("result transaction with no expectation");
            else
            begin
                logic exp_hit;
                exp_hit = expected_hits.pop_front();
                if (hit_out.hit !== exp_hit)
                    report_mismatch($sformatf("hit %b, expected %b", hit_out.hit, exp_hit));
            end
        end
    end

endmodule
